>>> rtl/rff_pkg.sv
// shared types, constants and codes for the random fourier feature map
// used by rff_ctrl, rff_dp and random_fourier_feature_map_top
`default_nettype none

package rff_pkg;

	localparam int IN_DIM  = 8;
	localparam int OUT_DIM = 64;

	localparam int OP_W      = 2;
	localparam int ROW_W     = 3;
	localparam int FEAT_W    = 6;
	localparam int VAL_W     = 16;
	localparam int WADDR_W   = ROW_W + FEAT_W;
	localparam int ACC_W     = 40;
	localparam int ANG_W     = 41;
	localparam int CORD_W    = 33;
	localparam int ITER_N    = 16;
	localparam int ITER_W    = 4;
	localparam int DIM_CMP_W = 7;

	localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
	localparam logic [OP_W-1:0] OP_PHASE  = 2'd1;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

	localparam logic [DIM_CMP_W-1:0] IN_DIM_V    = DIM_CMP_W'(IN_DIM);
	localparam logic [DIM_CMP_W-1:0] IN_LAST_V   = DIM_CMP_W'(IN_DIM - 1);
	localparam logic [FEAT_W-1:0]    OUT_LAST_V  = FEAT_W'(OUT_DIM - 1);
	localparam logic [ITER_W-1:0]    ITER_LAST_V = ITER_W'(ITER_N - 1);

	// round(2^28 / (2 pi)): radians in q.24 to a 32-bit binary angle
	localparam logic [25:0] INV_TWO_PI_Q28 = 26'd42722830;
	localparam logic signed [CORD_W-1:0] CORDIC_X0 = 33'sd652032874;
	localparam logic signed [CORD_W-1:0] QTR_TURN  = 33'sd1073741824;
	localparam logic signed [CORD_W-1:0] HALF_TURN = 33'sd2147483648;
	localparam logic signed [63:0] RND_HALF = 64'sd17592186044416;
	localparam logic signed [63:0] SAT_MAX  = 64'sd32767;
	localparam logic signed [63:0] SAT_MIN  = -64'sd32768;

	localparam logic signed [CORD_W-1:0] ATAN_TURNS [ITER_N] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
		33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
		33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
		33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
	};

	// elaboration-time integer square root
	function automatic longint unsigned isqrt64(input longint unsigned v);
		longint unsigned rem;
		longint unsigned res;
		longint unsigned b;
		rem = v;
		res = 64'd0;
		b   = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	localparam longint unsigned SCALE_FULL = isqrt64((64'd1 << 61) / OUT_DIM);
	// sqrt(2 / OUT_DIM) in q.30
	localparam logic signed [CORD_W-1:0] SCALE_Q30 = CORD_W'(SCALE_FULL);

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [ROW_W-1:0]        in_index;
		logic [FEAT_W-1:0]       out_index;
		logic signed [VAL_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [FEAT_W-1:0]       feature_index;
		logic signed [VAL_W-1:0] feature;
		logic                    last;
	} result_t;

	typedef struct packed {
		logic              accept;
		logic              mac_issue;
		logic              pass_done;
		logic              emit_ang;
		logic              emit_mul;
		logic              emit_turn;
		logic              emit_fold;
		logic              cordic_step;
		logic              emit_scale;
		logic              out_load;
		logic              out_last;
		logic [FEAT_W-1:0] idx;
		logic [ITER_W-1:0] iter;
	} cmd_t;

	typedef struct packed {
		logic sample_go;
		logic last_row;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/rff_dp.sv
// datapath: weight, phase and accumulator memories, mac, angle scaling,
// iterative cordic, output scaling and the result register; uses rff_pkg
`default_nettype none

module rff_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rff_pkg::item_t  item,
	input  wire rff_pkg::cmd_t   cmd,
	output rff_pkg::status_t     st,
	output rff_pkg::result_t     result,
	output logic                 result_valid,
	input  wire logic            result_stall
);

	logic [rff_pkg::VAL_W-1:0] wmem [2**rff_pkg::WADDR_W];
	logic [rff_pkg::VAL_W-1:0] pmem [2**rff_pkg::FEAT_W];
	logic [rff_pkg::ACC_W-1:0] amem [2**rff_pkg::FEAT_W];

	logic [rff_pkg::ROW_W-1:0]        row_q;
	logic signed [rff_pkg::VAL_W-1:0] value_q;
	logic                             acc_zero_q;

	logic signed [rff_pkg::VAL_W-1:0] w_rd_q;
	logic [rff_pkg::VAL_W-1:0]        ph_rd_q;
	logic [rff_pkg::ACC_W-1:0]        acc_rd_q;

	logic                      v_s1, v_s2;
	logic [rff_pkg::FEAT_W-1:0] idx_s1, idx_s2;
	logic signed [31:0]        prod_s2;
	logic [rff_pkg::ACC_W-1:0] base_s2;

	logic [rff_pkg::ANG_W-1:0] angle_q;
	logic [46:0]               plo_q;
	logic signed [46:0]        phi_q;
	logic [31:0]               p_q;

	logic signed [rff_pkg::CORD_W-1:0] x_q, y_q, a_q;
	logic                              neg_q;
	logic signed [63:0]                mult_q;

	logic signed [31:0]                mac_prod;
	logic [rff_pkg::ANG_W-1:0]         angle_d;
	logic [46:0]                       plo_d;
	logic signed [46:0]                phi_d;
	logic [51:0]                       tsum;
	logic signed [rff_pkg::CORD_W-1:0] a_in, a_fold;
	logic                              neg_fold;
	logic signed [rff_pkg::CORD_W-1:0] dx, dy, atan_v, cos_v;
	logic signed [65:0]                scl_full;
	logic signed [63:0]                rnd;
	logic signed [rff_pkg::VAL_W-1:0]  feat_sat;

	// status
	always_comb begin
		st.sample_go = (item.op == rff_pkg::OP_SAMPLE) &&
			(rff_pkg::DIM_CMP_W'(item.in_index) < rff_pkg::IN_DIM_V);
		st.last_row  = (rff_pkg::DIM_CMP_W'(row_q) == rff_pkg::IN_LAST_V);
		st.out_free  = !result_valid || !result_stall;
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.accept && item.op == rff_pkg::OP_WEIGHT)
			wmem[{item.in_index, item.out_index}] <= item.value;
		w_rd_q <= wmem[{row_q, cmd.idx}];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && item.op == rff_pkg::OP_PHASE)
			pmem[item.out_index] <= item.value;
		ph_rd_q <= pmem[cmd.idx];
	end

	always_ff @(posedge clk) begin
		if (v_s2)
			amem[idx_s2] <= base_s2 + {{(rff_pkg::ACC_W-32){prod_s2[31]}}, prod_s2};
		acc_rd_q <= amem[cmd.idx];
	end

	// latched row and value of every accepted beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			row_q   <= item.in_index;
			value_q <= item.value;
		end
	end

	// accumulators read as zero until the first pass has written all of them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_zero_q <= 1'b1;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			if (cmd.pass_done)
				acc_zero_q <= 1'b0;
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
		end
	end

	assign mac_prod = w_rd_q * value_q;

	always_ff @(posedge clk) begin
		idx_s1  <= cmd.idx;
		idx_s2  <= idx_s1;
		prod_s2 <= mac_prod;
		base_s2 <= (row_q == '0 || acc_zero_q) ? '0 : acc_rd_q;
	end

	// angle in q.24 radians, then to binary angle via split multiply
	assign angle_d = {acc_rd_q[rff_pkg::ACC_W-1], acc_rd_q} +
		{{(rff_pkg::ANG_W-rff_pkg::VAL_W-11){1'b0}}, ph_rd_q, 11'b0};
	assign plo_d = angle_q[20:0] * rff_pkg::INV_TWO_PI_Q28;
	assign phi_d = $signed(angle_q[rff_pkg::ANG_W-1:21]) * $signed({1'b0, rff_pkg::INV_TWO_PI_Q28});
	assign tsum  = {phi_q[30:0], 21'b0} + {5'b0, plo_q};

	// fold into a quarter turn either side of zero
	always_comb begin
		a_in     = $signed({p_q[31], p_q});
		a_fold   = a_in;
		neg_fold = 1'b0;
		if (a_in > rff_pkg::QTR_TURN) begin
			a_fold   = a_in - rff_pkg::HALF_TURN;
			neg_fold = 1'b1;
		end else if (a_in < -rff_pkg::QTR_TURN) begin
			a_fold   = a_in + rff_pkg::HALF_TURN;
			neg_fold = 1'b1;
		end
	end

	assign dx     = y_q >>> cmd.iter;
	assign dy     = x_q >>> cmd.iter;
	assign atan_v = rff_pkg::ATAN_TURNS[cmd.iter];
	assign cos_v  = neg_q ? -x_q : x_q;
	assign scl_full = cos_v * rff_pkg::SCALE_Q30;

	always_ff @(posedge clk) begin
		if (cmd.emit_ang)
			angle_q <= angle_d;
		if (cmd.emit_mul) begin
			plo_q <= plo_d;
			phi_q <= phi_d;
		end
		if (cmd.emit_turn)
			p_q <= tsum[51:20];
		if (cmd.emit_fold) begin
			a_q   <= a_fold;
			neg_q <= neg_fold;
			x_q   <= rff_pkg::CORDIC_X0;
			y_q   <= '0;
		end else if (cmd.cordic_step) begin
			if (!a_q[rff_pkg::CORD_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				a_q <= a_q - atan_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				a_q <= a_q + atan_v;
			end
		end
		if (cmd.emit_scale)
			mult_q <= scl_full[63:0];
	end

	// round half up and saturate to q1.15
	always_comb begin
		rnd = (mult_q + rff_pkg::RND_HALF) >>> 45;
		if (rnd > rff_pkg::SAT_MAX)
			feat_sat = 16'sh7FFF;
		else if (rnd < rff_pkg::SAT_MIN)
			feat_sat = -16'sh8000;
		else
			feat_sat = rnd[rff_pkg::VAL_W-1:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			if (cmd.out_load)
				result_valid <= 1'b1;
			else if (!result_stall)
				result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.feature_index <= cmd.idx;
			result.feature       <= feat_sat;
			result.last          <= cmd.out_last;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rff_ctrl.sv
// controller: sequences loads, the mac pass over all features and the
// per-feature emission steps; uses rff_pkg command and status types
`default_nettype none

module rff_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire rff_pkg::status_t st,
	output rff_pkg::cmd_t         cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MAC    = 4'd1;
	localparam logic [3:0] S_DRAIN1 = 4'd2;
	localparam logic [3:0] S_DRAIN2 = 4'd3;
	localparam logic [3:0] S_RD     = 4'd4;
	localparam logic [3:0] S_ANG    = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_TURN   = 4'd7;
	localparam logic [3:0] S_FOLD   = 4'd8;
	localparam logic [3:0] S_CORD   = 4'd9;
	localparam logic [3:0] S_SCL    = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	logic [3:0]                 state_q, state_d;
	logic [rff_pkg::FEAT_W-1:0] idx_q, idx_d;
	logic [rff_pkg::ITER_W-1:0] iter_q, iter_d;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		iter_d     = iter_q;
		item_stall = 1'b1;
		cmd        = '0;
		cmd.idx    = idx_q;
		cmd.iter   = iter_q;
		unique case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				cmd.accept = item_valid;
				if (item_valid && st.sample_go) begin
					state_d = S_MAC;
					idx_d   = '0;
				end
			end
			S_MAC: begin
				cmd.mac_issue = 1'b1;
				if (idx_q == rff_pkg::OUT_LAST_V)
					state_d = S_DRAIN1;
				else
					idx_d = idx_q + 1'b1;
			end
			S_DRAIN1: state_d = S_DRAIN2;
			S_DRAIN2: begin
				// last accumulator write lands at this edge
				cmd.pass_done = 1'b1;
				idx_d = '0;
				state_d = st.last_row ? S_RD : S_IDLE;
			end
			S_RD: begin
				// accumulator and phase of idx are read at this edge
				state_d = S_ANG;
			end
			S_ANG: begin
				cmd.emit_ang = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.emit_mul = 1'b1;
				state_d = S_TURN;
			end
			S_TURN: begin
				cmd.emit_turn = 1'b1;
				state_d = S_FOLD;
			end
			S_FOLD: begin
				cmd.emit_fold = 1'b1;
				iter_d  = '0;
				state_d = S_CORD;
			end
			S_CORD: begin
				cmd.cordic_step = 1'b1;
				if (iter_q == rff_pkg::ITER_LAST_V)
					state_d = S_SCL;
				else
					iter_d = iter_q + 1'b1;
			end
			S_SCL: begin
				cmd.emit_scale = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = (idx_q == rff_pkg::OUT_LAST_V);
					if (idx_q == rff_pkg::OUT_LAST_V) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			iter_q  <= iter_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/random_fourier_feature_map_top.sv
// random fourier feature map, cosine form: rff_ctrl sequences rff_dp
// load beats are written directly into the stores; a sample element runs one mac per cycle
// over the accumulator memory, and the last element then sends every feature in turn
// through the shared iterative cordic, subject to any output stall
// reset clears control state and marks accumulators as zero; stores are undefined until written
`default_nettype none

module random_fourier_feature_map_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire rff_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output rff_pkg::result_t      result
);

	rff_pkg::cmd_t    cmd;
	rff_pkg::status_t st;

	rff_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.st         (st),
		.cmd        (cmd)
	);

	rff_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.st           (st),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

`default_nettype wire

>>> sim/random_fourier_feature_map_top_tb.sv
// self-checking testbench for random_fourier_feature_map_top: loads weights and phases,
// streams sample vectors, and checks every emitted feature against an in-bench predictor
// depends on rff_pkg (beat types, op codes, dimensions) and the top level rtl
`timescale 1ns / 100ps

module random_fourier_feature_map_top_tb;

	import rff_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int LIMIT_CYCLES = 2000000;
	localparam int RANDOM_BEATS = 200;
	localparam int MAX_REPORTS = 40;

	// cordic constants on a 32-bit binary angle, full turn is 2^32
	localparam longint RAD_TO_TURN = 64'd42722830;
	localparam longint CORDIC_GAIN_X = 64'd652032874;
	localparam longint BA_QUARTER = 64'd1073741824;
	localparam longint BA_HALF = 64'd2147483648;
	localparam longint ATAN_STEP [16] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861
	};

	typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item_beat = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result_beat;

	random_fourier_feature_map_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item_beat),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result_beat)
	);

	// predictor state
	logic signed [VAL_W-1:0] weight_mem [512];
	logic [VAL_W-1:0] phase_mem [64];
	logic [ACC_W-1:0] dot_acc [64];
	longint feature_scale;

	item_t pending_items[$];
	result_t expected_features[$];
	int items_queued = 0;
	int items_accepted = 0;
	int items_sent = 0;
	int error_count = 0;
	int cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint root_floor(input longint v);
		longint lo;
		longint hi;
		longint mid;
		lo = 0;
		hi = 64'd3037000499;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// scaled cosine of (accumulator + phase), q1.15 saturated
	function automatic logic signed [VAL_W-1:0] cosine_feature(input logic [ACC_W-1:0] acc,
			input logic [VAL_W-1:0] phase);
		longint angle;
		longint turns;
		longint a;
		longint x;
		longint y;
		longint dx;
		longint dy;
		longint f;
		logic [31:0] p;
		bit flip;
		angle = longint'(signed'(acc)) + (longint'(phase) << 11);
		turns = angle * RAD_TO_TURN;
		p = turns[51:20];
		a = longint'(signed'(p));
		flip = 1'b0;
		x = CORDIC_GAIN_X;
		y = 0;
		// fold into the right half plane, cosine changes sign
		if (a > BA_QUARTER) begin
			a = a - BA_HALF;
			flip = 1'b1;
		end else if (a < -BA_QUARTER) begin
			a = a + BA_HALF;
			flip = 1'b1;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (a >= 0) begin
				x = x - dx;
				y = y + dy;
				a = a - ATAN_STEP[i];
			end else begin
				x = x + dx;
				y = y - dy;
				a = a + ATAN_STEP[i];
			end
		end
		if (flip) x = -x;
		f = (x * feature_scale + (longint'(1) << 44)) >>> 45;
		if (f > 32767) f = 32767;
		if (f < -32768) f = -32768;
		return f[VAL_W-1:0];
	endfunction

	task automatic apply_item(input item_t it);
		longint prod;
		result_t r;
		if (it.op == OP_WEIGHT) begin
			weight_mem[{it.in_index, it.out_index}] = it.value;
		end else if (it.op == OP_PHASE) begin
			phase_mem[it.out_index] = it.value;
		end else if (it.op == OP_SAMPLE && it.in_index < IN_DIM) begin
			for (int j = 0; j < OUT_DIM; j++) begin
				prod = longint'(weight_mem[{it.in_index, FEAT_W'(j)}]) * longint'(it.value);
				if (it.in_index == 0) dot_acc[j] = prod[ACC_W-1:0];
				else dot_acc[j] = dot_acc[j] + prod[ACC_W-1:0];
			end
			if (it.in_index == IN_DIM - 1) begin
				for (int j = 0; j < OUT_DIM; j++) begin
					r.feature_index = FEAT_W'(j);
					r.feature = cosine_feature(dot_acc[j], phase_mem[j]);
					r.last = (j == OUT_DIM - 1);
					expected_features.push_back(r);
				end
			end
		end
	endtask

	task automatic queue_beat(input logic [OP_W-1:0] op, input int row, input int col,
			input logic [VAL_W-1:0] val);
		item_t it;
		it.op = op;
		it.in_index = ROW_W'(row);
		it.out_index = FEAT_W'(col);
		it.value = val;
		pending_items.push_back(it);
		items_queued++;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return 16'h7fff;
		if (k == 1) return 16'h8000;
		if (k == 2) return VAL_W'($urandom_range(0, 511) - 256);
		return VAL_W'($urandom);
	endfunction

	// sampled at the rising edge: a beat is taken when valid is high and stall is low
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			apply_item(item_beat);
			items_accepted++;
		end
	end

	// sender: bursts of beats with gaps between them, payload held while stalled
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!(item_valid && items_accepted != items_sent)) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item_beat <= pending_items.pop_front();
				item_valid <= 1'b1;
				items_sent++;
				if (burst_left > 0) begin
					burst_left--;
				end else if ($urandom_range(0, 3) == 0) begin
					gap_left = 0;
					burst_left = $urandom_range(32, 64);
				end else begin
					gap_left = $urandom_range(1, 6);
					burst_left = $urandom_range(0, 11);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern re-picks one of four modes after each random hold
	stall_mode_e stall_mode = STALL_NONE;
	int stall_hold = 0;
	int stall_tick = 0;
	always @(negedge clk) begin
		if (stall_hold == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_hold = $urandom_range(50, 400);
		end
		stall_hold--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE: result_stall <= 1'b0;
			STALL_SPARSE: result_stall <= ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: result_stall <= ((stall_tick % 16) < 10);
			default: result_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// checker
	result_t want;
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_features.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected beat idx %0d feature %0d last %0b", $time,
						result_beat.feature_index, result_beat.feature, result_beat.last);
			end else begin
				want = expected_features.pop_front();
				if (result_beat.feature_index !== want.feature_index ||
						result_beat.feature !== want.feature ||
						result_beat.last !== want.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: expected idx %0d feature %0d last %0b, got idx %0d feature %0d last %0b",
							$time, want.feature_index, want.feature, want.last,
							result_beat.feature_index, result_beat.feature, result_beat.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int random_beats;
		int roll;
		int n;
		feature_scale = root_floor((longint'(1) << 61) / OUT_DIM);

		// fill both stores so that no sample reads an unwritten entry
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 64; c++)
				queue_beat(OP_WEIGHT, r, c, pick_value());
		queue_beat(OP_PHASE, 0, 0, 16'h0000);
		queue_beat(OP_PHASE, 0, 1, 16'hffff);
		queue_beat(OP_PHASE, 0, 2, 16'h8000);
		for (int c = 3; c < 64; c++)
			queue_beat(OP_PHASE, 0, c, VAL_W'($urandom));

		// directed: full-scale samples, spare op, reloads, out-of-order, zero vector
		for (int r = 0; r < IN_DIM; r++)
			queue_beat(OP_SAMPLE, r, $urandom_range(0, 63), r[0] ? 16'h8000 : 16'h7fff);
		queue_beat(OP_SPARE, $urandom_range(0, 7), $urandom_range(0, 63), VAL_W'($urandom));
		queue_beat(OP_WEIGHT, 3, 5, 16'h8000);
		queue_beat(OP_PHASE, 0, 63, 16'h7fff);
		queue_beat(OP_SAMPLE, 0, 0, pick_value());
		queue_beat(OP_SAMPLE, 5, 0, pick_value());
		queue_beat(OP_SAMPLE, 2, 0, pick_value());
		queue_beat(OP_SAMPLE, 0, 0, pick_value());
		// last element twice: accumulators carry over into the second emission
		queue_beat(OP_SAMPLE, 7, 63, pick_value());
		queue_beat(OP_SAMPLE, 7, 0, pick_value());
		for (int r = 0; r < IN_DIM; r++)
			queue_beat(OP_SAMPLE, r, 0, 16'h0000);

		// random: mostly whole vectors, some loads, noise and broken vectors
		random_beats = 0;
		while (random_beats < RANDOM_BEATS) begin
			roll = $urandom_range(0, 9);
			if (roll < 6) begin
				for (int r = 0; r < IN_DIM; r++) begin
					if ($urandom_range(0, 5) == 0) begin
						if ($urandom_range(0, 1) == 0)
							queue_beat(OP_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 63),
								pick_value());
						else
							queue_beat(OP_PHASE, $urandom_range(0, 7), $urandom_range(0, 63),
								VAL_W'($urandom));
						random_beats++;
					end
					queue_beat(OP_SAMPLE, r, $urandom_range(0, 63), pick_value());
					random_beats++;
				end
			end else if (roll < 8) begin
				n = $urandom_range(1, 10);
				for (int k = 0; k < n; k++) begin
					queue_beat(OP_SAMPLE, $urandom_range(0, 7), $urandom_range(0, 63),
						pick_value());
					random_beats++;
				end
			end else if (roll == 8) begin
				n = $urandom_range(1, 8);
				for (int k = 0; k < n; k++) begin
					queue_beat(OP_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 63),
						pick_value());
					queue_beat(OP_PHASE, $urandom_range(0, 7), $urandom_range(0, 63),
						VAL_W'($urandom));
					random_beats += 2;
				end
			end else begin
				n = $urandom_range(1, 3);
				for (int k = 0; k < n; k++)
					queue_beat(OP_SPARE, $urandom_range(0, 7), $urandom_range(0, 63),
						VAL_W'($urandom));
			end
		end

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (items_accepted != items_queued || expected_features.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
